@@ rtl/bouncing_bar_scanner_assert.svh @@
// Assertion helpers used by the scanner top-level RTL.
// Both macros expect clk and rst to be visible at the place of use.
`ifndef BOUNCING_BAR_SCANNER_ASSERT_SVH
`define BOUNCING_BAR_SCANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, checked outside reset.
`define BBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

@@ rtl/bbs_pkg.sv @@
package bbs_pkg;

  // Field and register widths
  localparam int CFG_W        = 16;
  localparam int POS_W        = 16;
  localparam int POS_BITS_DEF = 16;

  // Snake lengths at or above this leave the tail at zero on a set-position beat
  localparam logic [CFG_W-1:0] FULL_SIZE = 16'd100;

  // Register reset values
  localparam logic [CFG_W-1:0] BAR_MAX_RST      = 16'd100;
  localparam logic [CFG_W-1:0] STEP_SIZE_RST    = 16'd1;
  localparam logic [CFG_W-1:0] SNAKE_LENGTH_RST = 16'd100;
  localparam logic             ALLOW_REV_RST    = 1'b0;

  // Item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // Register indexes
  typedef enum logic [1:0] {
    REG_BAR_MAX      = 2'd0,
    REG_STEP_SIZE    = 2'd1,
    REG_SNAKE_LENGTH = 2'd2,
    REG_ALLOW_REV    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] bar_max;
    logic [CFG_W-1:0] step_size;
    logic [CFG_W-1:0] snake_length;
    logic             allow_reverse;
  } cfg_t;

  // Direction and drain flags of the snake
  typedef struct packed {
    logic reversed;
    logic draining;
  } flags_t;

endpackage

@@ rtl/bouncing_bar_scanner.sv @@
// Bouncing bar scanner: moves a head/tail segment along positions 0..bar_max.
// Each input beat is either a tick (mode 0) or a set-position (mode 1) and
// yields one result beat carrying the new head, tail, direction and drain
// flag. Throughput is one beat per clock cycle while out_ready is high; a
// beat passes the input register and then the state register, which also
// serves as the result register. The next-state logic is a handful of adds
// and compares between those two registers. Configuration writes take effect
// on the next cycle and must be made while no beat is in flight.
module bouncing_bar_scanner import bbs_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [POS_W-1:0] new_position,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] head_pos,
  output logic [POS_W-1:0] tail_pos,
  output logic             moving_back,
  output logic             tail_draining
);

  localparam int XW = ((POS_BITS > POS_W) ? POS_BITS : POS_W);

  cfg_t                cfg;
  logic                s1_valid;
  logic                s1_mode;
  logic [POS_W-1:0]    s1_pos;
  logic                s1_fire;
  logic [POS_BITS-1:0] head, tail, head_next, tail_next;
  flags_t              flags, flags_next;

  bbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bbs_step #(.POS_BITS(POS_BITS)) u_step (
    .cfg          (cfg),
    .mode         (s1_mode),
    .new_position (s1_pos),
    .head         (head),
    .tail         (tail),
    .flags        (flags),
    .head_next    (head_next),
    .tail_next    (tail_next),
    .flags_next   (flags_next)
  );

  // Advance the input stage whenever the result register is free or drains
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_pos  <= new_position;
    end
  end

  // State register, doubling as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      flags     <= '0;
    end else begin
      if (s1_fire) begin
        out_valid <= 1'b1;
        head      <= head_next;
        tail      <= tail_next;
        flags     <= flags_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign head_pos      = POS_W'(XW'(head));
  assign tail_pos      = POS_W'(XW'(tail));
  assign moving_back   = flags.reversed;
  assign tail_draining = flags.draining;

`include "bouncing_bar_scanner_assert.svh"

  // Input stalls only behind a held result
  `BBS_ASSERT_NOW(a_stall_cause, !in_ready, s1_valid && out_valid && !out_ready)
  // Every beat leaving the input stage shows up as a result
  `BBS_ASSERT_NEXT(a_fire_result, s1_fire, out_valid)
  // Snake state moves only when a beat is processed
  `BBS_ASSERT_NEXT(a_state_hold, !s1_fire, $stable(head) && $stable(tail) && $stable(flags))

endmodule

@@ rtl/bbs_cfg.sv @@
module bbs_cfg import bbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  // Write the addressed register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bar_max       <= BAR_MAX_RST;
      cfg.step_size     <= STEP_SIZE_RST;
      cfg.snake_length  <= SNAKE_LENGTH_RST;
      cfg.allow_reverse <= ALLOW_REV_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BAR_MAX:      cfg.bar_max       <= cfg_data;
        REG_STEP_SIZE:    cfg.step_size     <= cfg_data;
        REG_SNAKE_LENGTH: cfg.snake_length  <= cfg_data;
        REG_ALLOW_REV:    cfg.allow_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bbs_step.sv @@
module bbs_step import bbs_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  cfg_t                cfg,
  input  logic                mode,
  input  logic [POS_W-1:0]    new_position,
  input  logic [POS_BITS-1:0] head,
  input  logic [POS_BITS-1:0] tail,
  input  flags_t              flags,
  output logic [POS_BITS-1:0] head_next,
  output logic [POS_BITS-1:0] tail_next,
  output flags_t              flags_next
);

  // Working width: holds any position or register plus one carry bit
  localparam int EW = ((POS_BITS > CFG_W) ? POS_BITS : CFG_W) + 1;

  // Step toward the far end, clamped at mx
  function automatic logic [EW-1:0] fwd(input logic [EW-1:0] x, input logic [EW-1:0] st,
                                        input logic [EW-1:0] mx);
    logic [EW-1:0] s;
    s = x + st;
    return (s < mx) ? s : mx;
  endfunction

  // Step toward zero, saturated at zero
  function automatic logic [EW-1:0] bwd(input logic [EW-1:0] x, input logic [EW-1:0] st);
    return (x > st) ? (x - st) : '0;
  endfunction

  logic [EW-1:0]       mx, st, len, h, t;
  logic [EW-1:0]       h_step, t_step, p_clamp, h_set;
  logic [POS_BITS-1:0] h_mv, t_mv;
  logic                tail_follows;

  assign mx  = EW'(cfg.bar_max);
  assign st  = EW'(cfg.step_size);
  assign len = EW'(cfg.snake_length);
  assign h   = EW'(head);
  assign t   = EW'(tail);

  // Ordinary move of head, then tail against the moved head
  assign h_step = flags.reversed ? bwd(h, st) : fwd(h, st, mx);
  assign h_mv   = POS_BITS'(h_step);
  assign t_step = flags.reversed ? bwd(t, st) : fwd(t, st, mx);
  assign t_mv   = POS_BITS'(t_step);
  assign tail_follows = flags.draining ||
                        !(flags.reversed ? (mx < (EW'(h_mv) + len)) : (EW'(h_mv) < len));

  // Set-position: clamp to the bar, then derive the tail
  assign p_clamp = (EW'(new_position) > mx) ? mx : EW'(new_position);
  assign h_set   = EW'(POS_BITS'(p_clamp));

  // Next state for one beat
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    flags_next = flags;
    if (mode == MODE_SET) begin
      head_next = POS_BITS'(h_set);
      if (cfg.snake_length >= FULL_SIZE) begin
        tail_next = '0;
      end else begin
        tail_next = POS_BITS'(bwd(h_set, len));
      end
    end else if (!flags.reversed) begin
      if (h >= mx) begin
        if (cfg.allow_reverse || (t < mx)) begin
          // Parked at the far end: drain, then bounce back
          head_next = POS_BITS'(mx);
          priority if (!flags.draining) begin
            flags_next.draining = 1'b1;
          end else if (t >= mx) begin
            flags_next.draining = 1'b0;
            flags_next.reversed = 1'b1;
            head_next           = POS_BITS'(bwd(mx, st));
            tail_next           = POS_BITS'(mx);
          end else begin
            tail_next = t_mv;
          end
        end else begin
          // Restart from zero
          head_next  = '0;
          tail_next  = '0;
          flags_next = '0;
        end
      end else begin
        head_next = h_mv;
        if (tail_follows) tail_next = t_mv;
      end
    end else begin
      if (h == '0) begin
        // Parked at zero: drain, then head forward again
        head_next = '0;
        priority if (!flags.draining) begin
          flags_next.draining = 1'b1;
        end else if (t == '0) begin
          flags_next.draining = 1'b0;
          flags_next.reversed = 1'b0;
          head_next           = POS_BITS'((st < mx) ? st : mx);
          tail_next           = '0;
        end else begin
          tail_next = t_mv;
        end
      end else begin
        head_next = h_mv;
        if (tail_follows) tail_next = t_mv;
      end
    end
  end

endmodule
